// ===== sv/cfr_pkg.sv =====
`timescale 1ns / 1ps
package cfr_pkg;

	localparam int MAX_PAYLOAD = 30;
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

	localparam logic [7:0]  HEADER_BYTE  = 8'hC5;
	localparam logic [15:0] LEN_OVERHEAD = 16'd5;
	// longest total length still accepted by the length check: payload store plus 7
	localparam logic [15:0] LEN_LIMIT    = 16'(MAX_PAYLOAD + 7);

	typedef struct packed {
		logic              start;
		logic              bad;
		logic [7:0]        command;
		logic [CNT_W-1:0]  count;
	} frame_done_t;

	typedef struct packed {
		logic busy;
		logic can_load;
	} ro_status_t;

	typedef struct packed {
		logic       status;
		logic [7:0] command;
		logic [4:0] payload_length;
		logic [4:0] byte_index;
		logic [7:0] payload_byte;
		logic       last;
	} result_t;

endpackage

// ===== sv/cfr_ifs.sv =====
`timescale 1ns / 1ps
interface cfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] command;
	logic [4:0] payload_length;
	logic [4:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output status, output command, output payload_length,
		output byte_index, output payload_byte, output last, input ready);
	modport sink (input valid, input status, input command, input payload_length,
		input byte_index, input payload_byte, input last, output ready);
endinterface

// ===== sv/cfr_ram.sv =====
`timescale 1ns / 1ps
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cfr_parser.sv =====
`timescale 1ns / 1ps
module cfr_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	input  cfr_pkg::ro_status_t            ro_stat,
	output cfr_pkg::frame_done_t           done,
	output logic                           mem_we,
	output logic [cfr_pkg::ADDR_W-1:0]     mem_waddr,
	output logic [7:0]                     mem_wdata
);

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_LEN_LO  = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_CMD     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CHK     = 3'd5;

	logic [2:0]                  phase_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  cmd_q;
	logic [15:0]                 len_q;
	logic [cfr_pkg::CNT_W-1:0]   cnt_q;
	logic                        accept;
	logic [15:0]                 len_full;
	logic [cfr_pkg::CNT_W-1:0]   cnt_next;
	logic                        overflow;

	// the checksum byte needs a free output register for its result
	assign in_ready = !ro_stat.busy && (phase_q != PH_CHK || ro_stat.can_load);
	assign accept   = in_valid && in_ready;
	assign len_full = {rx_byte, len_q[7:0]};
	assign cnt_next = cnt_q + cfr_pkg::CNT_W'(1);
	assign overflow = cnt_q >= cfr_pkg::CNT_W'(cfr_pkg::MAX_PAYLOAD);

	assign mem_we    = accept && phase_q == PH_PAYLOAD && !overflow;
	assign mem_waddr = cfr_pkg::ADDR_W'(cnt_q);
	assign mem_wdata = rx_byte;

	assign done.start   = accept && phase_q == PH_CHK;
	assign done.bad     = sum_q != rx_byte;
	assign done.command = cmd_q;
	assign done.count   = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN_LO: begin
					len_q   <= {8'd0, rx_byte};
					sum_q   <= sum_q + rx_byte;
					phase_q <= PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_q   <= len_full;
					sum_q   <= sum_q + rx_byte;
					phase_q <= (len_full > cfr_pkg::LEN_LIMIT) ? PH_HUNT : PH_CMD;
				end
				PH_CMD: begin
					cmd_q   <= rx_byte;
					sum_q   <= sum_q + rx_byte;
					cnt_q   <= '0;
					phase_q <= (len_q > cfr_pkg::LEN_OVERHEAD) ? PH_PAYLOAD : PH_CHK;
				end
				PH_PAYLOAD: begin
					if (overflow) begin
						// store full: drop the frame without a result
						cnt_q   <= '0;
						phase_q <= PH_HUNT;
					end else begin
						cnt_q <= cnt_next;
						sum_q <= sum_q + rx_byte;
						if (16'(cnt_next) >= len_q - cfr_pkg::LEN_OVERHEAD) begin
							phase_q <= PH_CHK;
						end
					end
				end
				PH_CHK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
					if (rx_byte == cfr_pkg::HEADER_BYTE) begin
						sum_q   <= rx_byte;
						phase_q <= PH_LEN_LO;
					end
				end
			endcase
		end
	end

endmodule

// ===== sv/cfr_readout.sv =====
`timescale 1ns / 1ps
module cfr_readout (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfr_pkg::frame_done_t           done,
	output cfr_pkg::ro_status_t            ro_stat,
	output logic                           mem_re,
	output logic [cfr_pkg::ADDR_W-1:0]     mem_raddr,
	input  logic [7:0]                     mem_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cfr_pkg::result_t               out_data
);

	localparam logic [1:0] RO_IDLE = 2'd0;
	localparam logic [1:0] RO_READ = 2'd1;
	localparam logic [1:0] RO_WAIT = 2'd2;

	logic [1:0]                  state_q;
	logic [cfr_pkg::ADDR_W-1:0]  idx_q;
	logic [7:0]                  cmd_q;
	logic [cfr_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;
	cfr_pkg::result_t            out_q;
	logic                        can_load;
	logic [cfr_pkg::CNT_W-1:0]   idx_next;
	logic                        idx_last;
	logic                        load_single;
	logic                        load_byte;

	assign can_load    = !out_valid_q || out_ready;
	assign idx_next    = cfr_pkg::CNT_W'(idx_q) + cfr_pkg::CNT_W'(1);
	assign idx_last    = idx_next == cnt_q;
	assign load_single = done.start && (done.bad || done.count == '0);
	assign load_byte   = state_q == RO_WAIT && can_load;

	assign ro_stat.busy     = state_q != RO_IDLE;
	assign ro_stat.can_load = can_load;

	assign mem_re    = state_q == RO_READ;
	assign mem_raddr = idx_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RO_IDLE;
			idx_q       <= '0;
			cmd_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_single || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				RO_IDLE: begin
					if (done.start && !load_single) begin
						cmd_q   <= done.command;
						cnt_q   <= done.count;
						idx_q   <= '0;
						state_q <= RO_READ;
					end
				end
				RO_READ: begin
					state_q <= RO_WAIT;
				end
				RO_WAIT: begin
					if (can_load) begin
						if (idx_last) begin
							state_q <= RO_IDLE;
						end else begin
							idx_q   <= idx_q + cfr_pkg::ADDR_W'(1);
							state_q <= RO_READ;
						end
					end
				end
				default: begin
					state_q <= RO_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			out_q.status         <= done.bad;
			out_q.command        <= done.command;
			out_q.payload_length <= 5'(done.count);
			out_q.byte_index     <= '0;
			out_q.payload_byte   <= '0;
			out_q.last           <= 1'b1;
		end else if (load_byte) begin
			out_q.status         <= 1'b0;
			out_q.command        <= cmd_q;
			out_q.payload_length <= 5'(cnt_q);
			out_q.byte_index     <= 5'(idx_q);
			out_q.payload_byte   <= mem_rdata;
			out_q.last           <= idx_last;
		end
	end

endmodule

// ===== sv/checksummed_frame_receiver.sv =====
`timescale 1ns / 1ps
// Frame receiver: hunts for header byte 0xC5, then takes a 16-bit little-endian
// total length, a command byte, up to 30 payload bytes and an 8-bit additive
// checksum. Frames that are too long or overflow the payload store are dropped
// with no result. While parsing, one byte is accepted per cycle unless the
// readout is busy or, for the checksum byte, the output holds an untaken item.
// The checksum byte of a bad frame or of a frame with no payload yields one
// result item; a good frame with N payload bytes yields N items read back from
// the payload RAM (read, then present); no byte is accepted during readout. The
// output register lets a waiting result stand while parsing goes on.
module checksummed_frame_receiver (
	input  logic          clk,
	input  logic          arst_n,
	cfr_byte_if.sink      rx,
	cfr_result_if.source  res
);

	cfr_pkg::ro_status_t          ro_stat;
	cfr_pkg::frame_done_t         done;
	cfr_pkg::result_t             out_data;
	logic                         mem_we;
	logic [cfr_pkg::ADDR_W-1:0]   mem_waddr;
	logic [7:0]                   mem_wdata;
	logic                         mem_re;
	logic [cfr_pkg::ADDR_W-1:0]   mem_raddr;
	logic [7:0]                   mem_rdata;

	cfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.rx_byte   (rx.rx_byte),
		.ro_stat   (ro_stat),
		.done      (done),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	cfr_ram #(
		.WIDTH (8),
		.DEPTH (cfr_pkg::MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cfr_readout u_readout (
		.clk       (clk),
		.arst_n    (arst_n),
		.done      (done),
		.ro_stat   (ro_stat),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);

	assign res.status         = out_data.status;
	assign res.command        = out_data.command;
	assign res.payload_length = out_data.payload_length;
	assign res.byte_index     = out_data.byte_index;
	assign res.payload_byte   = out_data.payload_byte;
	assign res.last           = out_data.last;

	// no byte taken while the payload is being read back
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.valid && rx.ready && ro_stat.busy))
		else $error("byte accepted during readout");

	// store is never written while it is being read out
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !ro_stat.busy)
		else $error("payload write during readout");

	// a bad frame gives one final item flagged bad right away
	assert property (@(posedge clk) disable iff (!arst_n)
		done.start && done.bad |=> res.valid && res.last && res.status)
		else $error("bad frame result missing");

	// an item that is not the last of its frame is always a good payload byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> !res.status && res.payload_length != 5'd0)
		else $error("non-final item is not a payload byte");

endmodule
